// File: rtl/fba_pkg.sv
// Shared types, constants and helper functions of the frame bitmap allocator.
// No dependencies; imported by every module of the block.
package fba_pkg;

   // Field widths fixed by the page entry format
   localparam int FRAME_W          = 15;
   localparam int FCOUNT_W         = 16;
   localparam int MAP_WORD_W       = 32;
   localparam int BIT_IDX_W        = 5;
   // Word counter: 32768 searchable frames / 32 = 1024 words, plus one
   localparam int WORD_CNT_W       = 11;
   localparam int FRAME_FIELD_LIMIT = 32768;

   localparam int                  FBA_MAX_FRAMES = 32768;
   localparam logic [FCOUNT_W-1:0] FCOUNT_RESET   = 16'd32768;
   localparam logic [MAP_WORD_W-1:0] FULL_WORD    = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      RSP_ALLOCATED     = 3'd0,
      RSP_HAD_FRAME     = 3'd1,
      RSP_OUT_OF_FRAMES = 3'd2,
      RSP_FREED         = 3'd3,
      RSP_NOTHING       = 3'd4
   } fba_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_ALLOC_WR,
      ST_FREE_WR,
      ST_RESP
   } fba_state_type;

   // Controller to datapath
   typedef struct packed {
      logic           clear_step;
      logic           capture;
      logic           scan_step;
      logic           free_read;
      logic           alloc_write;
      logic           free_write;
      logic           res_load;
      fba_status_type res_sel;
   } fba_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic is_free;
      logic frame_zero;
      logic in_range;
      logic scan_hit;
      logic scan_empty;
   } fba_stat_type;

   // Index of the lowest clear bit of a bitmap word
   function automatic logic [BIT_IDX_W-1:0] fba_first_zero(input logic [MAP_WORD_W-1:0] word);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            idx = BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// File: rtl/frame_bitmap_allocator_top.sv
// Top level of the first-fit page frame bitmap allocator.
// Depends on fba_pkg, fba_ctrl and fba_datapath.

// A request is taken when start is high and busy is low; its single result
// appears for one cycle with rsp_strobe and cannot be held off. After reset
// the block sweeps its bitmap memory clear, one word per cycle, with busy
// high. An allocation whose entry holds no frame scans the bitmap one word
// per cycle through the single memory read port, over frame_count/32 complete
// words capped by storage and the frame field limit, and reports out of frames
// when no searched word has a clear bit. A free of a frame inside storage does
// a read-modify-write of one word; other frees write nothing. Busy stays high
// until the result has been given, so a new request is taken only after it.
module frame_bitmap_allocator_top
   import fba_pkg::*;
#(
   parameter int MAX_FRAMES = FBA_MAX_FRAMES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [FCOUNT_W-1:0] csr_wdata,
   input  logic                start,
   output logic                busy,
   input  logic                req_opcode,
   input  logic [FRAME_W-1:0]  req_page_frame,
   input  logic                req_is_kernel,
   input  logic                req_is_writable,
   output logic                rsp_strobe,
   output logic [2:0]          rsp_status,
   output logic [FRAME_W-1:0]  rsp_new_frame,
   output logic                rsp_present_bit,
   output logic                rsp_rw_bit,
   output logic                rsp_user_bit
);

   fba_cmd_type  cmd;
   fba_stat_type st;

   fba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .st         (st),
      .cmd        (cmd)
   );

   fba_datapath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_opcode      (req_opcode),
      .req_page_frame  (req_page_frame),
      .req_is_kernel   (req_is_kernel),
      .req_is_writable (req_is_writable),
      .cmd             (cmd),
      .st              (st),
      .rsp_status      (rsp_status),
      .rsp_new_frame   (rsp_new_frame),
      .rsp_present_bit (rsp_present_bit),
      .rsp_rw_bit      (rsp_rw_bit),
      .rsp_user_bit    (rsp_user_bit)
   );

   // A transfer in keeps the block busy in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request transfer");

   // A result is a single-cycle strobe issued while a request is in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy ##1 !rsp_strobe)
      else $error("result strobe outside a request or longer than one cycle");

   // An allocated entry is always marked present
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == RSP_ALLOCATED)) |-> rsp_present_bit)
      else $error("allocated entry not marked present");

   // Non-allocation results never carry rw or user flags
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != RSP_ALLOCATED)) |-> (!rsp_rw_bit && !rsp_user_bit))
      else $error("flags set on a result other than an allocation");

endmodule

// File: rtl/fba_ctrl.sv
// Sequencing state machine of the frame bitmap allocator.
// Depends on fba_pkg for the state, command and status types.
module fba_ctrl
   import fba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   input  fba_stat_type st,
   output fba_cmd_type  cmd
);

   fba_state_type state_ff, state_in;

   // Hold the state; sweep the bitmap clear after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.res_sel = RSP_ALLOCATED;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (st.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!st.is_free) begin
               if (!st.frame_zero) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RSP_HAD_FRAME;
                  state_in     = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end else if (st.frame_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RSP_NOTHING;
               state_in     = ST_RESP;
            end else if (st.in_range) begin
               cmd.free_read = 1'b1;
               state_in      = ST_FREE_WR;
            end else begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RSP_FREED;
               state_in     = ST_RESP;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_hit) begin
               state_in = ST_ALLOC_WR;
            end else if (st.scan_empty) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RSP_OUT_OF_FRAMES;
               state_in     = ST_RESP;
            end
         end
         ST_ALLOC_WR: begin
            cmd.alloc_write = 1'b1;
            cmd.res_load    = 1'b1;
            cmd.res_sel     = RSP_ALLOCATED;
            state_in        = ST_RESP;
         end
         ST_FREE_WR: begin
            cmd.free_write = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_sel    = RSP_FREED;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);

endmodule

// File: rtl/fba_datapath.sv
// Bitmap memory, scan pointers, request and result registers of the allocator.
// Depends on fba_pkg; driven by fba_ctrl through command and status structs.
module fba_datapath
   import fba_pkg::*;
#(
   parameter int MAX_FRAMES = FBA_MAX_FRAMES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [FCOUNT_W-1:0]   csr_wdata,
   input  logic                  req_opcode,
   input  logic [FRAME_W-1:0]    req_page_frame,
   input  logic                  req_is_kernel,
   input  logic                  req_is_writable,
   input  fba_cmd_type           cmd,
   output fba_stat_type          st,
   output logic [2:0]            rsp_status,
   output logic [FRAME_W-1:0]    rsp_new_frame,
   output logic                  rsp_present_bit,
   output logic                  rsp_rw_bit,
   output logic                  rsp_user_bit
);

   localparam int MAP_WORDS    = (MAX_FRAMES + 31) / 32;
   localparam int AW           = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int SEARCH_LIMIT = (MAX_FRAMES < FRAME_FIELD_LIMIT) ? MAX_FRAMES
                                                                  : FRAME_FIELD_LIMIT;

   logic [MAP_WORD_W-1:0] mem [MAP_WORDS];

   logic [FCOUNT_W-1:0]   fcount_ff;
   logic                  op_ff, kernel_ff, writable_ff;
   logic [FRAME_W-1:0]    pframe_ff;
   logic [WORD_CNT_W-1:0] words_ff;
   logic [AW-1:0]         clr_ptr_ff;
   logic [WORD_CNT_W-1:0] scan_ptr_ff, chk_ptr_ff;
   logic                  pend_ff;
   logic [MAP_WORD_W-1:0] rd_data_ff;
   logic [AW-1:0]         alloc_addr_ff;
   logic [MAP_WORD_W-1:0] alloc_word_ff;
   logic [FRAME_W-1:0]    found_frame_ff;
   fba_status_type        res_status_ff;
   logic [FRAME_W-1:0]    res_frame_ff;
   logic                  res_present_ff, res_rw_ff, res_user_ff;

   logic [FCOUNT_W-1:0]   limit;
   logic                  issue, hit, mem_re, mem_we;
   logic [AW-1:0]         free_addr, mem_raddr, mem_waddr;
   logic [MAP_WORD_W-1:0] mem_wdata;
   logic [BIT_IDX_W-1:0]  zero_idx;

   // Words searched: complete words under the smallest of frame_count, storage and the frame field limit
   assign limit = (fcount_ff > FCOUNT_W'(SEARCH_LIMIT)) ? FCOUNT_W'(SEARCH_LIMIT) : fcount_ff;

   // Hold the frame count register
   always_ff @(posedge clock) begin
      if (reset) begin
         fcount_ff <= FCOUNT_RESET;
      end else if (csr_we) begin
         fcount_ff <= csr_wdata;
      end
   end

   // Capture the request on transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_opcode;
         pframe_ff   <= req_page_frame;
         kernel_ff   <= req_is_kernel;
         writable_ff <= req_is_writable;
         words_ff    <= limit[FCOUNT_W-1:BIT_IDX_W];
      end
   end

   // Advance the clearing sweep and the scan pointers
   assign hit   = pend_ff && (rd_data_ff != FULL_WORD);
   assign issue = cmd.scan_step && (scan_ptr_ff < words_ff) && !hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff  <= '0;
         scan_ptr_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ptr_ff <= clr_ptr_ff + AW'(1);
         end
         if (cmd.capture) begin
            scan_ptr_ff <= '0;
            pend_ff     <= 1'b0;
         end else if (cmd.scan_step) begin
            pend_ff <= issue;
            if (issue) begin
               scan_ptr_ff <= scan_ptr_ff + WORD_CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         chk_ptr_ff <= scan_ptr_ff;
      end
   end

   // Latch the first word with a clear bit and the frame taken from it
   assign zero_idx = fba_first_zero(rd_data_ff);

   always_ff @(posedge clock) begin
      if (cmd.scan_step && hit) begin
         alloc_addr_ff  <= AW'(chk_ptr_ff);
         alloc_word_ff  <= rd_data_ff | (MAP_WORD_W'(1) << zero_idx);
         found_frame_ff <= FRAME_W'({chk_ptr_ff, zero_idx});
      end
   end

   // Memory port selection
   assign free_addr = AW'(pframe_ff[FRAME_W-1:BIT_IDX_W]);
   assign mem_re    = issue || cmd.free_read;
   assign mem_raddr = cmd.free_read ? free_addr : AW'(scan_ptr_ff);
   assign mem_we    = cmd.clear_step || cmd.alloc_write || cmd.free_write;

   always_comb begin
      mem_waddr = clr_ptr_ff;
      mem_wdata = '0;
      if (cmd.alloc_write) begin
         mem_waddr = alloc_addr_ff;
         mem_wdata = alloc_word_ff;
      end else if (cmd.free_write) begin
         mem_waddr = free_addr;
         mem_wdata = rd_data_ff & ~(MAP_WORD_W'(1) << pframe_ff[BIT_IDX_W-1:0]);
      end
   end

   // Bitmap memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // Build the result entry
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_sel;
         case (cmd.res_sel)
            RSP_ALLOCATED: begin
               res_frame_ff   <= found_frame_ff;
               res_present_ff <= 1'b1;
               res_rw_ff      <= writable_ff;
               res_user_ff    <= !kernel_ff;
            end
            RSP_HAD_FRAME: begin
               res_frame_ff   <= pframe_ff;
               res_present_ff <= 1'b1;
               res_rw_ff      <= 1'b0;
               res_user_ff    <= 1'b0;
            end
            default: begin
               res_frame_ff   <= '0;
               res_present_ff <= 1'b0;
               res_rw_ff      <= 1'b0;
               res_user_ff    <= 1'b0;
            end
         endcase
      end
   end

   assign st.clear_last = (clr_ptr_ff == AW'(MAP_WORDS - 1));
   assign st.is_free    = op_ff;
   assign st.frame_zero = (pframe_ff == '0);
   assign st.in_range   = (32'(pframe_ff) < 32'(MAX_FRAMES));
   assign st.scan_hit   = hit;
   assign st.scan_empty = !pend_ff && (scan_ptr_ff >= words_ff);

   assign rsp_status      = res_status_ff;
   assign rsp_new_frame   = res_frame_ff;
   assign rsp_present_bit = res_present_ff;
   assign rsp_rw_bit      = res_rw_ff;
   assign rsp_user_bit    = res_user_ff;

endmodule

// File: dv/fba_tb_pkg.sv
// Request codes shared by the allocator testbench modules.
// No dependencies; imported by the checker and the testbench top.
`timescale 1ns / 1ps
package fba_tb_pkg;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } fba_op_type;

endpackage

// File: dv/fba_checker.sv
// Bitmap allocator checker: predicts each page entry update and compares results.
// Depends on fba_pkg and fba_tb_pkg; watches the ports of frame_bitmap_allocator_top.
`timescale 1ns / 1ps
module fba_checker
   import fba_pkg::*;
   import fba_tb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [FCOUNT_W-1:0] csr_wdata,
   input  logic                start,
   input  logic                busy,
   input  logic                req_opcode,
   input  logic [FRAME_W-1:0]  req_page_frame,
   input  logic                req_is_kernel,
   input  logic                req_is_writable,
   input  logic                rsp_strobe,
   input  logic [2:0]          rsp_status,
   input  logic [FRAME_W-1:0]  rsp_new_frame,
   input  logic                rsp_present_bit,
   input  logic                rsp_rw_bit,
   input  logic                rsp_user_bit,
   output int                  fail_count,
   output int                  open_count
);

   localparam int MAP_WORDS = (FBA_MAX_FRAMES + MAP_WORD_W - 1) / MAP_WORD_W;

   typedef struct {
      fba_status_type     status;
      logic [FRAME_W-1:0] frame;
      logic               present;
      logic               rw;
      logic               user;
   } page_entry_type;

   // Shadow of the used-frame bitmap and the frame count register
   logic [MAP_WORD_W-1:0] frame_used [MAP_WORDS];
   logic [FCOUNT_W-1:0]   frame_limit;
   page_entry_type        pending_entries [$];

   // Work out the page entry update for one request and apply it to the shadow map
   function automatic page_entry_type resolve_request(input logic op,
                                                      input logic [FRAME_W-1:0] pf,
                                                      input logic kern,
                                                      input logic wr);
      page_entry_type e;
      int unsigned    span, words, w, b, pick;
      bit             found;
      e.status  = RSP_NOTHING;
      e.frame   = '0;
      e.present = 1'b0;
      e.rw      = 1'b0;
      e.user    = 1'b0;
      found     = 1'b0;
      pick      = 0;
      if (op == OP_ALLOC) begin
         if (pf != '0) begin
            e.status  = RSP_HAD_FRAME;
            e.frame   = pf;
            e.present = 1'b1;
         end else begin
            // Only complete words up to the storage and frame field limits are searched
            span = 32'(frame_limit);
            if (span > FBA_MAX_FRAMES) span = FBA_MAX_FRAMES;
            if (span > FRAME_FIELD_LIMIT) span = FRAME_FIELD_LIMIT;
            words = span / MAP_WORD_W;
            for (w = 0; w < words && !found; w++) begin
               if (frame_used[w] != FULL_WORD) begin
                  for (b = 0; b < MAP_WORD_W && !found; b++) begin
                     if (!frame_used[w][b]) begin
                        found = 1'b1;
                        pick  = w * MAP_WORD_W + b;
                     end
                  end
               end
            end
            if (found) begin
               frame_used[pick / MAP_WORD_W][pick % MAP_WORD_W] = 1'b1;
               e.status  = RSP_ALLOCATED;
               e.frame   = FRAME_W'(pick);
               e.present = 1'b1;
               e.rw      = wr;
               e.user    = !kern;
            end else begin
               e.status = RSP_OUT_OF_FRAMES;
            end
         end
      end else if (pf != '0) begin
         // Frames past storage are left alone but still report freed
         if (pf < FBA_MAX_FRAMES) begin
            frame_used[pf / MAP_WORD_W][pf % MAP_WORD_W] = 1'b0;
         end
         e.status = RSP_FREED;
      end
      return e;
   endfunction

   // Track register writes, queue predictions on request transfers, check results
   always @(posedge clock) begin : watch
      page_entry_type want;
      int             errs;
      errs = 0;
      if (reset) begin
         foreach (frame_used[i]) frame_used[i] = '0;
         frame_limit = FCOUNT_RESET;
         pending_entries.delete();
         open_count <= 0;
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            frame_limit = csr_wdata;
         end
         if (rsp_strobe) begin
            if (pending_entries.size() == 0) begin
               $error("result transfer with no request outstanding");
               errs++;
            end else begin
               want = pending_entries.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errs++;
               end
               if (rsp_new_frame !== want.frame) begin
                  $error("new_frame: expected %0d, got %0d", want.frame, rsp_new_frame);
                  errs++;
               end
               if (rsp_present_bit !== want.present) begin
                  $error("present_bit: expected %0b, got %0b", want.present, rsp_present_bit);
                  errs++;
               end
               if (rsp_rw_bit !== want.rw) begin
                  $error("rw_bit: expected %0b, got %0b", want.rw, rsp_rw_bit);
                  errs++;
               end
               if (rsp_user_bit !== want.user) begin
                  $error("user_bit: expected %0b, got %0b", want.user, rsp_user_bit);
                  errs++;
               end
            end
         end
         if (start && !busy) begin
            pending_entries.push_back(resolve_request(req_opcode, req_page_frame,
                                                      req_is_kernel, req_is_writable));
         end
         open_count <= pending_entries.size();
         fail_count <= fail_count + errs;
      end
   end

endmodule

// File: dv/tb.sv
// Testbench top for frame_bitmap_allocator_top: drives requests and register writes.
// Depends on fba_pkg, fba_tb_pkg, fba_checker and the allocator RTL.
`timescale 1ns / 1ps
module tb
   import fba_pkg::*;
   import fba_tb_pkg::*;
();

   localparam int RANDOM_ITEMS = 580;
   localparam int PHASES       = 10;
   localparam int CALM_TAIL    = 60;

   logic                clock;
   logic                reset           = 1'b1;
   logic                csr_we          = 1'b0;
   logic [FCOUNT_W-1:0] csr_wdata       = '0;
   logic                start           = 1'b0;
   logic                busy;
   logic                req_opcode      = OP_ALLOC;
   logic [FRAME_W-1:0]  req_page_frame  = '0;
   logic                req_is_kernel   = 1'b0;
   logic                req_is_writable = 1'b0;
   logic                rsp_strobe;
   logic [2:0]          rsp_status;
   logic [FRAME_W-1:0]  rsp_new_frame;
   logic                rsp_present_bit;
   logic                rsp_rw_bit;
   logic                rsp_user_bit;
   int                  fail_count;
   int                  open_count;

   // Frames handed out and not yet given back, used to build well-formed frees
   int unsigned         held_frames [$];

   frame_bitmap_allocator_top dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_page_frame  (req_page_frame),
      .req_is_kernel   (req_is_kernel),
      .req_is_writable (req_is_writable),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_new_frame   (rsp_new_frame),
      .rsp_present_bit (rsp_present_bit),
      .rsp_rw_bit      (rsp_rw_bit),
      .rsp_user_bit    (rsp_user_bit)
   );

   fba_checker alloc_check (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_page_frame  (req_page_frame),
      .req_is_kernel   (req_is_kernel),
      .req_is_writable (req_is_writable),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_new_frame   (rsp_new_frame),
      .rsp_present_bit (rsp_present_bit),
      .rsp_rw_bit      (rsp_rw_bit),
      .rsp_user_bit    (rsp_user_bit),
      .fail_count      (fail_count),
      .open_count      (open_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Collect allocated frames; frame zero can never be freed, so leave it out
   always @(posedge clock) begin
      if (!reset && rsp_strobe && rsp_status == RSP_ALLOCATED && rsp_new_frame != '0) begin
         held_frames.push_back(32'(rsp_new_frame));
      end
   end

   // Present one request after an optional gap and hold it until transferred
   task automatic send_request(input fba_op_type op, input logic [FRAME_W-1:0] pf,
                               input logic kern, input logic wr, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_opcode      <= op;
      req_page_frame  <= pf;
      req_is_kernel   <= kern;
      req_is_writable <= wr;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start and wait until every result is in and the block is idle
   task automatic drain_block();
      start <= 1'b0;
      @(posedge clock);
      while (open_count != 0 || busy) @(posedge clock);
   endtask

   task automatic write_frame_count(input logic [FCOUNT_W-1:0] value);
      drain_block();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly allocations and frees of held frames, with some stray requests mixed in
   task automatic random_request(input bit calm);
      int                 roll;
      int                 gap;
      int                 idx;
      logic [FRAME_W-1:0] pf;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         send_request(OP_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      gap);
      end else if (roll < 85 && held_frames.size() > 0) begin
         idx = $urandom_range(0, held_frames.size() - 1);
         pf  = FRAME_W'(held_frames[idx]);
         held_frames.delete(idx);
         send_request(OP_FREE, pf, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      gap);
      end else if (roll < 93) begin
         send_request(OP_ALLOC, FRAME_W'($urandom_range(1, 32767)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gap);
      end else if (roll < 97) begin
         send_request(OP_FREE, FRAME_W'($urandom_range(1, 32767)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gap);
      end else begin
         send_request(OP_FREE, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      gap);
      end
   endtask

   initial begin
      logic [FCOUNT_W-1:0] phase_counts [PHASES];
      int                  done;
      phase_counts = '{16'd64, 16'd65535, 16'd96, 16'd1000, 16'd31,
                       16'd40000, 16'd33, 16'd2048, 16'd0, 16'd32768};
      done = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: frame zero handed out, field extremes, every status
      send_request(OP_ALLOC, '0, 1'b0, 1'b1, 0);
      send_request(OP_ALLOC, '0, 1'b1, 1'b0, 0);
      send_request(OP_ALLOC, '0, 1'b1, 1'b1, 0);
      send_request(OP_ALLOC, 15'h7FFF, 1'b0, 1'b1, 0);
      send_request(OP_ALLOC, 15'd1, 1'b1, 1'b0, 0);
      send_request(OP_FREE, '0, 1'b1, 1'b1, 0);
      send_request(OP_FREE, 15'd1, 1'b0, 1'b0, 0);
      send_request(OP_ALLOC, '0, 1'b0, 1'b0, 0);
      send_request(OP_FREE, 15'h7FFF, 1'b1, 1'b1, 0);
      send_request(OP_FREE, 15'h2AAA, 1'b0, 1'b1, 0);
      send_request(OP_FREE, 15'h5555, 1'b1, 1'b0, 0);
      // No complete word to search: out of frames
      write_frame_count(16'd0);
      send_request(OP_ALLOC, '0, 1'b0, 1'b1, 0);
      send_request(OP_FREE, 15'd2, 1'b0, 1'b0, 0);
      write_frame_count(16'd31);
      send_request(OP_ALLOC, '0, 1'b1, 1'b1, 0);
      // Oversized count is capped at storage
      write_frame_count(16'd65535);
      send_request(OP_ALLOC, '0, 1'b0, 1'b0, 0);
      send_request(OP_ALLOC, '0, 1'b1, 1'b1, 0);

      // Random phases across several frame counts; no gaps in the closing stretch
      for (int p = 0; p < PHASES; p++) begin
         write_frame_count(phase_counts[p]);
         for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
            random_request(done >= RANDOM_ITEMS - CALM_TAIL);
            done++;
         end
      end

      drain_block();
      repeat (16) @(posedge clock);
      if (fail_count == 0 && open_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
